// ===== src/pcgbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcgbr_pkg
// Shared types, constants and helper functions for the bounded PCG8 generator.
// ----------------------------------------------------------------------------
package pcgbr_pkg;

    typedef logic [7:0] t_byte;

    // Generator constants
    localparam t_byte LCG_MULT            = 8'd141;
    localparam t_byte OUT_MULT            = 8'd217;
    localparam t_byte SEED_STATE_RESET    = 8'd42;
    localparam t_byte SEED_SEQUENCE_RESET = 8'd54;
    // State after default seeding: inc = 2*54+1, state from set-seq
    localparam t_byte LCG_INC_RESET       = 8'd109;
    localparam t_byte LCG_STATE_RESET     = 8'd152;

    // Configuration register indexes
    typedef enum logic {
        CFG_SEED_STATE    = 1'b0,
        CFG_SEED_SEQUENCE = 1'b1
    } t_cfg_reg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_THRESH,
        ST_DRAW,
        ST_REMAIN,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_bound;   // latch request, start threshold remainder
        logic draw;         // advance the LCG one step
        logic start_remain; // start remainder of accepted draw
        logic load_out;     // load the output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic bound_zero;   // incoming bound is zero
        logic mod_done;     // remainder unit finished this cycle
        logic draw_ok;      // current draw reaches the threshold
    } t_dp_sts;

    // One LCG step: state * 141 + inc, mod 256
    function automatic t_byte lcg_next(input t_byte s, input t_byte inc);
        logic [15:0] prod;
        prod = {8'd0, s} * {8'd0, LCG_MULT};
        return prod[7:0] + inc;
    endfunction

    // RXS-M-XS output permutation
    function automatic t_byte permute(input t_byte s);
        logic [2:0]  sh;
        t_byte       x;
        logic [15:0] prod;
        t_byte       w;
        sh   = 3'(s[7:6]) + 3'd2;
        x    = (s >> sh) ^ s;
        prod = {8'd0, x} * {8'd0, OUT_MULT};
        w    = prod[7:0];
        return (w >> 6) ^ w;
    endfunction

endpackage

// ===== src/pcgbr_req_if.sv =====
// ----------------------------------------------------------------------------
// pcgbr_req_if
// Request channel: valid/ready handshake carrying the bound.
// ----------------------------------------------------------------------------
interface pcgbr_req_if
    import pcgbr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte bound;

    modport source (output valid, output bound, input ready);
    modport sink   (input valid, input bound, output ready);
endinterface

// ===== src/pcgbr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pcgbr_rsp_if
// Response channel: valid/ready handshake carrying value and error flag.
// ----------------------------------------------------------------------------
interface pcgbr_rsp_if
    import pcgbr_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte value;
    logic  bad_bound;

    modport source (output valid, output value, output bad_bound, input ready);
    modport sink   (input valid, input value, input bad_bound, output ready);
endinterface

// ===== src/pcgbr_mod.sv =====
// ----------------------------------------------------------------------------
// pcgbr_mod
// Iterative 8-bit remainder unit, restoring, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pcgbr_mod
    import pcgbr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_byte i_dividend,
    input  t_byte i_divisor,
    output t_byte o_rem,
    output logic  o_done
);

    t_byte      r_rem, n_rem;
    t_byte      r_dvd, n_dvd;
    t_byte      r_div;
    logic [2:0] r_cnt, n_cnt;
    logic       r_busy, n_busy;
    logic       r_done, n_done;

    logic [8:0] partial;
    logic [8:0] diff;

    always_comb begin
        partial = {r_rem, r_dvd[7]};
        diff    = partial - {1'b0, r_div};
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = (partial >= {1'b0, r_div}) ? diff[7:0] : partial[7:0];
            n_dvd = {r_dvd[6:0], 1'b0};
            n_cnt = r_cnt + 3'd1;
            if (r_cnt == 3'd7) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

// ===== src/pcgbr_dp.sv =====
// ----------------------------------------------------------------------------
// pcgbr_dp
// Datapath: seed registers, LCG state, output permutation, remainder unit
// and output register.
// ----------------------------------------------------------------------------
module pcgbr_dp
    import pcgbr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_addr,
    input  t_byte   i_cfg_data,
    input  t_byte   i_bound,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_byte   o_value,
    output logic    o_bad_bound
);

    t_byte r_seed_state, r_seed_seq;
    t_byte r_lcg_state, r_lcg_inc;
    t_byte r_bound;
    logic  r_bad;
    t_byte r_out_value;
    logic  r_out_bad;

    t_byte seed_state_new, seed_seq_new, inc_new, state_new;
    t_byte perm;
    t_byte mod_rem;
    logic  mod_done;
    logic  mod_start;
    t_byte mod_dividend, mod_divisor;

    // Reseed: inc = 2*seq+1, state = ((0*m + inc) + seed)*m + inc
    always_comb begin
        seed_state_new = (t_cfg_reg'(i_cfg_addr) == CFG_SEED_STATE)    ? i_cfg_data
                                                                        : r_seed_state;
        seed_seq_new   = (t_cfg_reg'(i_cfg_addr) == CFG_SEED_SEQUENCE) ? i_cfg_data
                                                                        : r_seed_seq;
        inc_new        = {seed_seq_new[6:0], 1'b1};
        state_new      = lcg_next(inc_new + seed_state_new, inc_new);
    end

    // Remainder unit serves the threshold, then the accepted draw; between
    // the two its result holds the threshold.
    assign perm         = permute(r_lcg_state);
    assign mod_start    = i_cmd.load_bound | i_cmd.start_remain;
    assign mod_dividend = i_cmd.start_remain ? perm : (8'd0 - i_bound);
    assign mod_divisor  = i_cmd.start_remain ? r_bound : i_bound;

    pcgbr_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_rem      (mod_rem),
        .o_done     (mod_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_state <= SEED_STATE_RESET;
            r_seed_seq   <= SEED_SEQUENCE_RESET;
            r_lcg_state  <= LCG_STATE_RESET;
            r_lcg_inc    <= LCG_INC_RESET;
        end else if (i_cfg_we) begin
            r_seed_state <= seed_state_new;
            r_seed_seq   <= seed_seq_new;
            r_lcg_state  <= state_new;
            r_lcg_inc    <= inc_new;
        end else if (i_cmd.draw) begin
            r_lcg_state  <= lcg_next(r_lcg_state, r_lcg_inc);
        end
        if (i_cmd.load_bound) begin
            r_bound <= i_bound;
            r_bad   <= (i_bound == '0);
        end
        if (i_cmd.load_out) begin
            r_out_value <= r_bad ? '0 : mod_rem;
            r_out_bad   <= r_bad;
        end
    end

    assign o_sts.bound_zero = (i_bound == '0);
    assign o_sts.mod_done   = mod_done;
    assign o_sts.draw_ok    = (perm >= mod_rem);
    assign o_value          = r_out_value;
    assign o_bad_bound      = r_out_bad;

endmodule

// ===== src/pcgbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcgbr_ctrl
// Controller: sequences threshold, draws, remainder and output handshake.
// ----------------------------------------------------------------------------
module pcgbr_ctrl
    import pcgbr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        n_out_valid = r_out_valid && !i_rsp_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load_bound = 1'b1;
                    n_state = i_sts.bound_zero ? ST_EMIT : ST_THRESH;
                end
            end
            ST_THRESH: begin
                if (i_sts.mod_done) begin
                    n_state = ST_DRAW;
                end
            end
            ST_DRAW: begin
                o_cmd.draw = 1'b1;
                if (i_sts.draw_ok) begin
                    o_cmd.start_remain = 1'b1;
                    n_state = ST_REMAIN;
                end
            end
            ST_REMAIN: begin
                if (i_sts.mod_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_out_valid;

endmodule

// ===== src/pcg8_bounded_random.sv =====
// ----------------------------------------------------------------------------
// pcg8_bounded_random
// 8-bit PCG generator (LCG x141, RXS-M-XS output) with unbiased bounded draw.
// ----------------------------------------------------------------------------
// Each request transaction carries a bound from 1 to 255 and yields one
// response transaction with a uniform value below the bound. The block first
// works out the rejection threshold (256 - bound) mod bound, then draws one
// permuted output per cycle, advancing the LCG each time, until a draw reaches
// the threshold, and returns that draw mod bound. Both remainders go through
// one shared restoring remainder unit that retires one dividend bit per cycle.
// A new request is taken once the previous result sits in the output register,
// so a waiting response does not hold back the next request. A bound of zero
// goes from acceptance straight to the emit state, is answered with value 0
// and bad_bound set, and leaves the generator untouched. Writing either seed
// register (index 0 seed_state, index 1 seed_sequence) reseeds the generator
// in the same cycle by the set-seq routine; reset leaves the default seeding
// in place. Write the registers only while no request is in flight.
// ----------------------------------------------------------------------------
module pcg8_bounded_random
    import pcgbr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_addr,
    input  t_byte          i_cfg_data,
    pcgbr_req_if.sink      i_req,
    pcgbr_rsp_if.source    o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Controller: state machine and response valid flag
    pcgbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: generator state, remainder unit and output payload register
    pcgbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_bound     (i_req.bound),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_value     (o_rsp.value),
        .o_bad_bound (o_rsp.bad_bound)
    );

endmodule
